// ===== rtl/core/lom_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_pkg: shared types and constants of the limit order matcher
// Holds register reset values and indices, side, status and reason codes, field widths.
// ----------------------------------------------------------------------------
package lom_pkg;

  localparam int unsigned BookDepthDefault       = 16;
  localparam int unsigned InstrumentCountDefault = 5;

  localparam logic [15:0] MinQtyReset   = 16'd10;
  localparam logic [15:0] MaxQtyReset   = 16'd1000;
  localparam logic [15:0] LotSizeReset  = 16'd10;
  localparam logic [2:0]  MaxClenReset  = 3'd7;

  localparam logic [1:0] CfgMinQty  = 2'd0;
  localparam logic [1:0] CfgMaxQty  = 2'd1;
  localparam logic [1:0] CfgLotSize = 2'd2;
  localparam logic [1:0] CfgMaxClen = 2'd3;

  localparam logic [1:0] SideBuy  = 2'd1;
  localparam logic [1:0] SideSell = 2'd2;
  localparam logic [1:0] SideSum  = 2'd3;

  localparam logic [1:0] StNew    = 2'd0;
  localparam logic [1:0] StFill   = 2'd1;
  localparam logic [1:0] StPfill  = 2'd2;
  localparam logic [1:0] StReject = 2'd3;

  localparam logic [5:0] RsnClient = 6'h01;
  localparam logic [5:0] RsnInst   = 6'h02;
  localparam logic [5:0] RsnSide   = 6'h04;
  localparam logic [5:0] RsnPrice  = 6'h08;
  localparam logic [5:0] RsnSize   = 6'h10;
  localparam logic [5:0] RsnFull   = 6'h20;

  // Resting order record held in the book memory
  typedef struct packed {
    logic [31:0] price;
    logic [15:0] qty;
    logic [31:0] seq;
    logic [55:0] client;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  // One report
  typedef struct packed {
    logic        last;
    logic [5:0]  reason;
    logic [31:0] price;
    logic [15:0] qty;
    logic [1:0]  status;
    logic [1:0]  side;
    logic [2:0]  inst;
    logic [55:0] client;
    logic [31:0] seq;
  } report_t;

endpackage

// ===== rtl/core/lom_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lom_ram: generic simple dual-port RAM with registered read
// One write and one read address per cycle; read data appears next cycle.
// ----------------------------------------------------------------------------
module lom_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/limit_order_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher: price-time priority limit order book
// Validates orders, matches them against the opposite book and rests any
// remainder, emitting execution reports on a stream output.
// ----------------------------------------------------------------------------
// One order is taken at a time. A single compare unit walks the opposite
// book side one slot per cycle through a registered-read book memory.
// The checks work out the lot remainder one bit a cycle; a reject or a
// zero-quantity order is then done. Each match runs a best-price search,
// a decision and its two reports; when the search finds no crossing
// order, a free-slot search follows to rest the remainder. Output
// back-pressure adds its stall cycles to each report. Book slots carry
// valid bits held in flip-flops, cleared at reset.
module limit_order_matcher #(
  parameter int unsigned BOOK_DEPTH       = lom_pkg::BookDepthDefault,
  parameter int unsigned INSTRUMENT_COUNT = lom_pkg::InstrumentCountDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // client[55:0], client_len[59:56], instrument[62:60], side[64:63],
  // price[96:65], quantity[112:97], zero fill to 120
  input  logic [119:0]  s_axis_tdata,
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // order_seq[31:0], report_client[87:32], report_instrument[90:88],
  // report_side[92:91], report_status[94:93], report_quantity[110:95],
  // report_price[142:111], reason_mask[148:143], zero fill to 152
  output logic [151:0]  m_axis_tdata,
  output logic          m_axis_tlast
);

  localparam int unsigned Slots   = INSTRUMENT_COUNT * 2 * BOOK_DEPTH;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam int unsigned KW      = $clog2(BOOK_DEPTH + 1);
  localparam int unsigned DepthW  = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CHECK  = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_EMIT1  = 9'b000010000,
    S_EMIT2  = 9'b000100000,
    S_REST   = 9'b001000000,
    S_FINAL  = 9'b010000000,
    S_WAIT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [15:0] min_qty_q, max_qty_q, lot_q;
  logic [2:0]  max_clen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_qty_q  <= lom_pkg::MinQtyReset;
      max_qty_q  <= lom_pkg::MaxQtyReset;
      lot_q      <= lom_pkg::LotSizeReset;
      max_clen_q <= lom_pkg::MaxClenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lom_pkg::CfgMinQty:  min_qty_q  <= cfg_data_i;
        lom_pkg::CfgMaxQty:  max_qty_q  <= cfg_data_i;
        lom_pkg::CfgLotSize: lot_q      <= cfg_data_i;
        lom_pkg::CfgMaxClen: max_clen_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // order registers
  logic [55:0] client_q;
  logic [3:0]  clen_q;
  logic [2:0]  inst_q;
  logic [1:0]  side_q;
  logic [31:0] price_q;
  logic [15:0] qty_q, qty_d;
  logic [31:0] seq_q, seqcnt_q;
  logic        filled_q, filled_d;
  logic [15:0] lot_rem_q, lot_rem_d;
  logic [4:0]  lot_bit_q, lot_bit_d;

  // scan registers
  logic [KW-1:0]     k_q, k_d;
  logic              rd_vld_q;
  logic [DepthW-1:0] rd_k_q;
  logic              best_vld_q, best_vld_d;
  logic [DepthW-1:0] best_k_q, best_k_d;
  lom_pkg::entry_t   best_q, best_d;
  logic              free_vld_q, free_vld_d;
  logic [DepthW-1:0] free_k_q, free_k_d;

  logic [Slots-1:0] valid_q, valid_d;

  // output register
  lom_pkg::report_t rep_q, rep_d;
  logic             rep_vld_q, rep_vld_d;

  // memory
  logic                 we;
  logic [SlotW-1:0]     waddr, raddr;
  lom_pkg::entry_t      wdata, rdata;

  lom_ram #(.Width(lom_pkg::EntryWidth), .Depth(Slots)) u_book (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  logic is_sell;
  assign is_sell = (side_q == lom_pkg::SideSell);

  function automatic logic [SlotW-1:0] slot_addr(input logic [2:0] inst,
                                                  input logic sd,
                                                  input logic [DepthW-1:0] k);
    logic [SlotW+4:0] a;
    a = (SlotW+5)'(inst) * (SlotW+5)'(2 * BOOK_DEPTH)
      + (sd ? (SlotW+5)'(BOOK_DEPTH) : '0) + (SlotW+5)'(k);
    return a[SlotW-1:0];
  endfunction

  logic [SlotW-1:0] opp_addr, own_addr_free, best_addr;
  assign opp_addr      = slot_addr(inst_q, !is_sell, k_q[DepthW-1:0]);
  assign own_addr_free = slot_addr(inst_q, is_sell, free_k_q);
  assign best_addr     = slot_addr(inst_q, !is_sell, best_k_q);

  logic [SlotW-1:0] rd_addr_own;
  assign rd_addr_own = slot_addr(inst_q, !is_sell, rd_k_q);

  // candidate better than current best
  logic better;
  always_comb begin
    better = 1'b0;
    if (!best_vld_q) begin
      better = 1'b1;
    end else if (rdata.price == best_q.price) begin
      better = rdata.seq < best_q.seq;
    end else if (!is_sell) begin
      better = $signed(rdata.price) < $signed(best_q.price);
    end else begin
      better = $signed(rdata.price) > $signed(best_q.price);
    end
  end

  logic crosses;
  assign crosses = is_sell ? !($signed(best_q.price) < $signed(price_q))
                           : !($signed(best_q.price) > $signed(price_q));

  // validation reason, using the iterated lot remainder
  logic [5:0]  reason;
  logic [15:0] lot_eff;
  assign lot_eff = (lot_q == 16'd0) ? 16'd1 : lot_q;
  always_comb begin
    reason = '0;
    if (clen_q == 4'd0 || clen_q > {1'b0, max_clen_q}) reason |= lom_pkg::RsnClient;
    if ({29'd0, inst_q} >= 32'(INSTRUMENT_COUNT))      reason |= lom_pkg::RsnInst;
    if (side_q != lom_pkg::SideBuy && side_q != lom_pkg::SideSell)
      reason |= lom_pkg::RsnSide;
    if ($signed(price_q) <= 0)                         reason |= lom_pkg::RsnPrice;
    if (qty_q < min_qty_q || qty_q > max_qty_q || lot_rem_q != 16'd0)
      reason |= lom_pkg::RsnSize;
  end

  // restoring remainder step, one bit a cycle
  logic [31:0] lot_sh;
  logic [16:0] lot_try;
  assign lot_sh  = {16'd0, lot_eff} << lot_bit_q;
  assign lot_try = {1'b0, lot_rem_q} - lot_sh[16:0];

  function automatic lom_pkg::report_t mk(input logic [31:0] sq, input logic [55:0] cl,
      input logic [2:0] in, input logic [1:0] sd, input logic [1:0] st,
      input logic [15:0] q, input logic [31:0] p, input logic [5:0] r,
      input logic l);
    lom_pkg::report_t t;
    t.seq = sq; t.client = cl; t.inst = in; t.side = sd; t.status = st;
    t.qty = q; t.price = p; t.reason = r; t.last = l;
    return t;
  endfunction

  // the output register is free when empty or handed over this cycle
  logic rep_take;
  logic out_free;
  assign rep_take = m_axis_tvalid && m_axis_tready;
  assign out_free = !rep_vld_q || rep_take;

  // sequencer
  always_comb begin
    state_d    = state_q;
    qty_d      = qty_q;
    filled_d   = filled_q;
    lot_rem_d  = lot_rem_q;
    lot_bit_d  = lot_bit_q;
    k_d        = k_q;
    best_vld_d = best_vld_q;
    best_k_d   = best_k_q;
    best_d     = best_q;
    free_vld_d = free_vld_q;
    free_k_d   = free_k_q;
    valid_d    = valid_q;
    rep_d      = rep_q;
    rep_vld_d  = rep_vld_q && !rep_take;
    we         = 1'b0;
    waddr      = own_addr_free;
    wdata      = '0;
    raddr      = opp_addr;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          qty_d     = s_axis_tdata[112:97];
          lot_rem_d = s_axis_tdata[112:97];
          lot_bit_d = 5'd15;
          filled_d  = 1'b0;
          state_d   = S_CHECK;
        end
      end
      S_CHECK: begin
        // one remainder bit a cycle, then judge the order
        if (!lot_try[16] && lot_sh[31:16] == 16'd0) lot_rem_d = lot_try[15:0];
        if (lot_bit_q != 5'd0) begin
          lot_bit_d = lot_bit_q - 5'd1;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (reason != 6'd0) begin
          if (out_free) begin
            rep_d = mk(seq_q, client_q, inst_q, side_q, lom_pkg::StReject,
                       qty_q, price_q, reason, 1'b1);
            rep_vld_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (qty_q == 16'd0) begin
          if (out_free) begin
            rep_d = mk(seq_q, client_q, inst_q, side_q, lom_pkg::StNew,
                       16'd0, price_q, 6'd0, 1'b1);
            rep_vld_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          k_d = '0; best_vld_d = 1'b0; free_vld_d = 1'b0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue read k, compare read from previous cycle
        if (rd_vld_q && valid_q[rd_addr_own] && better) begin
          best_vld_d = 1'b1; best_k_d = rd_k_q; best_d = rdata;
        end
        if (k_q == KW'(BOOK_DEPTH)) begin
          state_d = S_DECIDE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_DECIDE: begin
        if (best_vld_q && crosses) begin
          state_d = S_EMIT1;
        end else begin
          k_d = '0;
          state_d = S_REST;
        end
      end
      S_EMIT1: begin
        if (out_free) begin
          rep_d = mk(seq_q, client_q, inst_q, side_q,
                     (best_q.qty < qty_q) ? lom_pkg::StPfill : lom_pkg::StFill,
                     (best_q.qty < qty_q) ? best_q.qty : qty_q,
                     best_q.price, 6'd0, 1'b0);
          rep_vld_d = 1'b1;
          state_d = S_EMIT2;
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          waddr = best_addr;
          rep_d = mk(best_q.seq, best_q.client, inst_q, lom_pkg::SideSum - side_q,
                     (best_q.qty > qty_q) ? lom_pkg::StPfill : lom_pkg::StFill,
                     (best_q.qty > qty_q) ? qty_q : best_q.qty,
                     best_q.price, 6'd0, best_q.qty >= qty_q);
          rep_vld_d = 1'b1;
          if (best_q.qty > qty_q) begin
            we = 1'b1;
            wdata = best_q;
            wdata.qty = best_q.qty - qty_q;
            state_d = S_IDLE;
          end else if (best_q.qty == qty_q) begin
            valid_d[best_addr] = 1'b0;
            state_d = S_IDLE;
          end else begin
            valid_d[best_addr] = 1'b0;
            qty_d = qty_q - best_q.qty;
            filled_d = 1'b1;
            k_d = '0; best_vld_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_REST: begin
        // find lowest free own slot, one per cycle
        if (!free_vld_q && k_q != KW'(BOOK_DEPTH)
            && !valid_q[slot_addr(inst_q, is_sell, k_q[DepthW-1:0])]) begin
          free_vld_d = 1'b1; free_k_d = k_q[DepthW-1:0];
        end
        if (k_q == KW'(BOOK_DEPTH)) begin
          state_d = S_FINAL;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_FINAL: begin
        if (!free_vld_q) begin
          if (out_free) begin
            rep_d = mk(seq_q, client_q, inst_q, side_q, lom_pkg::StReject,
                       qty_q, price_q, lom_pkg::RsnFull, 1'b1);
            rep_vld_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (!filled_q) begin
          if (out_free) begin
            we = 1'b1;
            wdata = '{price: price_q, qty: qty_q, seq: seq_q, client: client_q};
            valid_d[own_addr_free] = 1'b1;
            rep_d = mk(seq_q, client_q, inst_q, side_q, lom_pkg::StNew,
                       qty_q, price_q, 6'd0, 1'b1);
            rep_vld_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          // rest silently and mark the held fill report as the last one
          we = 1'b1;
          wdata = '{price: price_q, qty: qty_q, seq: seq_q, client: client_q};
          valid_d[own_addr_free] = 1'b1;
          rep_d.last = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      seqcnt_q  <= '0;
      valid_q   <= '0;
      rep_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      rep_vld_q <= rep_vld_d;
      rd_vld_q  <= (state_q == S_SCAN) && (k_q != KW'(BOOK_DEPTH));
      if (state_q == S_IDLE && s_axis_tvalid) seqcnt_q <= seqcnt_q + 32'd1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      client_q <= s_axis_tdata[55:0];
      clen_q   <= s_axis_tdata[59:56];
      inst_q   <= s_axis_tdata[62:60];
      side_q   <= s_axis_tdata[64:63];
      price_q  <= s_axis_tdata[96:65];
      seq_q    <= seqcnt_q + 32'd1;
    end
    qty_q     <= qty_d;
    filled_q  <= filled_d;
    lot_rem_q <= lot_rem_d;
    lot_bit_q <= lot_bit_d;
    k_q       <= k_d;
    rd_k_q    <= k_q[DepthW-1:0];
    best_vld_q <= best_vld_d;
    best_k_q  <= best_k_d;
    best_q    <= best_d;
    free_vld_q <= free_vld_d;
    free_k_q  <= free_k_d;
    rep_q     <= rep_d;
  end

  // The report of a fill that leaves a remainder is held until the next match
  // or the end of the order, so its last flag is known; stall the port meanwhile.
  logic hold_rep;
  assign hold_rep = filled_q && !rep_q.last &&
                    (state_q == S_SCAN || state_q == S_DECIDE || state_q == S_REST ||
                     (state_q == S_FINAL && free_vld_q));

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = rep_vld_q && !hold_rep;
  assign m_axis_tlast  = rep_q.last;
  assign m_axis_tdata  = {3'd0, rep_q.reason, rep_q.price, rep_q.qty, rep_q.status,
                          rep_q.side, rep_q.inst, rep_q.client, rep_q.seq};

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second order while busy");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> seqcnt_q == $past(seqcnt_q) + 32'd1)
    else $error("sequence counter did not advance");
  a_no_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> rep_vld_q)
    else $error("stalled report dropped");
`endif

endmodule

// ===== tb/sv/limit_order_matcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// limit_order_matcher_test: self-checking bench for the limit order matcher
// Streams limit orders into the block, predicts every execution report with
// a local price-time priority book, and checks the reports field by field
// under random idling on both streams and across several register settings.
// ----------------------------------------------------------------------------
module limit_order_matcher_test;

  localparam int unsigned Depth     = lom_pkg::BookDepthDefault;
  localparam int unsigned InstCount = lom_pkg::InstrumentCountDefault;
  localparam int unsigned HoldLen   = 400;
  localparam int unsigned StallMax  = 20000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_index_i = lom_pkg::CfgMinQty;
  logic [15:0]   cfg_data_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [119:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [151:0]  m_axis_tdata;
  logic          m_axis_tlast;

  limit_order_matcher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // orders waiting to be sent and reports still owed by the block
  logic [119:0]      order_q[$];
  lom_pkg::report_t  report_q[$];
  int unsigned  error_count = 0;
  int unsigned  send_idle = 0;
  int unsigned  recv_idle = 0;
  logic         hold_start = 1'b0;
  int unsigned  hold_left = 0;
  int unsigned  stall_cycles = 0;

  // local copy of the registers and books
  logic [15:0]        min_qty = lom_pkg::MinQtyReset;
  logic [15:0]        max_qty = lom_pkg::MaxQtyReset;
  logic [15:0]        lot_qty = lom_pkg::LotSizeReset;
  logic [2:0]         max_clen = lom_pkg::MaxClenReset;
  logic [31:0]        seq_count = '0;
  bit                 bk_valid [InstCount][2][Depth];
  logic signed [31:0] bk_price [InstCount][2][Depth];
  logic [15:0]        bk_qty   [InstCount][2][Depth];
  logic [31:0]        bk_seq   [InstCount][2][Depth];
  logic [55:0]        bk_client[InstCount][2][Depth];

  task automatic report_error(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void add_report(logic [31:0] seq, logic [55:0] client,
                                     logic [2:0] inst, logic [1:0] side,
                                     logic [1:0] status, logic [15:0] qty,
                                     logic [31:0] price, logic [5:0] reason);
    lom_pkg::report_t r;
    r.last = 1'b0; r.reason = reason; r.price = price; r.qty = qty;
    r.status = status; r.side = side; r.inst = inst; r.client = client;
    r.seq = seq;
    report_q.push_back(r);
  endfunction

  // Match one accepted order against the books and queue its reports
  function automatic void match_order(logic [119:0] d);
    logic [55:0]        client = d[55:0];
    logic [3:0]         clen = d[59:56];
    logic [2:0]         inst = d[62:60];
    logic [1:0]         side = d[64:63];
    logic signed [31:0] price = d[96:65];
    logic [15:0]        qty = d[112:97];
    logic [15:0]        lot = (lot_qty == 0) ? 16'd1 : lot_qty;
    logic [5:0]         reason = '0;
    int                 first = report_q.size();
    bit                 filled = 0;
    int                 own, opp, best, slot;
    logic [15:0]        rq;

    seq_count = seq_count + 1;
    if (clen == 0 || clen > max_clen) reason |= lom_pkg::RsnClient;
    if (inst >= InstCount) reason |= lom_pkg::RsnInst;
    if (side != lom_pkg::SideBuy && side != lom_pkg::SideSell) reason |= lom_pkg::RsnSide;
    if (price <= 0) reason |= lom_pkg::RsnPrice;
    if (qty < min_qty || qty > max_qty || (qty % lot) != 0) reason |= lom_pkg::RsnSize;

    if (reason != 0) begin
      add_report(seq_count, client, inst, side, lom_pkg::StReject, qty, price, reason);
    end else if (qty == 0) begin
      add_report(seq_count, client, inst, side, lom_pkg::StNew, '0, price, '0);
    end else begin
      own = (side == lom_pkg::SideSell) ? 1 : 0;
      opp = 1 - own;
      forever begin
        // best resting order: best price, then oldest sequence
        best = -1;
        for (int k = 0; k < Depth; k++) begin
          if (!bk_valid[inst][opp][k]) continue;
          if (best < 0) best = k;
          else if (bk_price[inst][opp][k] == bk_price[inst][opp][best]) begin
            if (bk_seq[inst][opp][k] < bk_seq[inst][opp][best]) best = k;
          end else if (opp == 1 ? bk_price[inst][opp][k] < bk_price[inst][opp][best]
                                : bk_price[inst][opp][k] > bk_price[inst][opp][best]) begin
            best = k;
          end
        end
        if (best < 0) break;
        if (own == 1 ? bk_price[inst][opp][best] < price
                     : bk_price[inst][opp][best] > price) break;
        rq = bk_qty[inst][opp][best];
        if (rq == qty) begin
          add_report(seq_count, client, inst, side, lom_pkg::StFill, qty,
                     bk_price[inst][opp][best], '0);
          add_report(bk_seq[inst][opp][best], bk_client[inst][opp][best], inst,
                     lom_pkg::SideSum - side, lom_pkg::StFill, rq,
                     bk_price[inst][opp][best], '0);
          bk_valid[inst][opp][best] = 0;
          qty = 0;
          break;
        end else if (rq > qty) begin
          add_report(seq_count, client, inst, side, lom_pkg::StFill, qty,
                     bk_price[inst][opp][best], '0);
          add_report(bk_seq[inst][opp][best], bk_client[inst][opp][best], inst,
                     lom_pkg::SideSum - side, lom_pkg::StPfill, qty,
                     bk_price[inst][opp][best], '0);
          bk_qty[inst][opp][best] = rq - qty;
          qty = 0;
          break;
        end else begin
          add_report(seq_count, client, inst, side, lom_pkg::StPfill, rq,
                     bk_price[inst][opp][best], '0);
          add_report(bk_seq[inst][opp][best], bk_client[inst][opp][best], inst,
                     lom_pkg::SideSum - side, lom_pkg::StFill, rq,
                     bk_price[inst][opp][best], '0);
          bk_valid[inst][opp][best] = 0;
          qty = qty - rq;
          filled = 1;
        end
      end
      // rest the remainder in the lowest free slot
      if (qty != 0) begin
        slot = -1;
        for (int k = Depth - 1; k >= 0; k--) if (!bk_valid[inst][own][k]) slot = k;
        if (slot < 0) begin
          add_report(seq_count, client, inst, side, lom_pkg::StReject, qty, price,
                     lom_pkg::RsnFull);
        end else begin
          bk_valid[inst][own][slot] = 1;
          bk_price[inst][own][slot] = price;
          bk_qty[inst][own][slot] = qty;
          bk_seq[inst][own][slot] = seq_count;
          bk_client[inst][own][slot] = client;
          if (!filled)
            add_report(seq_count, client, inst, side, lom_pkg::StNew, qty, price, '0);
        end
      end
    end
    if (report_q.size() > first) report_q[report_q.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [119:0] pack_order(logic [55:0] client, logic [3:0] clen,
                                              logic [2:0] inst, logic [1:0] side,
                                              logic [31:0] price, logic [15:0] qty);
    return {7'd0, qty, price, side, inst, clen, client};
  endfunction

  // Mostly well-formed orders on a narrow price band, some pure noise
  function automatic logic [119:0] random_order();
    logic [15:0] lot = (lot_qty == 0) ? 16'd1 : lot_qty;
    int unsigned kmax = (max_qty / lot < 1) ? 1 : ((max_qty / lot > 8) ? 8 : max_qty / lot);
    logic [55:0] client = 56'({$urandom, $urandom});
    if ($urandom_range(99) < 15)
      return pack_order(client, 4'($urandom), 3'($urandom), 2'($urandom), $urandom,
                        16'($urandom));
    return pack_order(client, 4'($urandom_range(1, max_clen == 0 ? 1 : max_clen)),
                      $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, InstCount - 1)),
                      $urandom_range(0, 1) ? lom_pkg::SideBuy : lom_pkg::SideSell,
                      $urandom_range(95, 105), 16'(lot * $urandom_range(1, kmax)));
  endfunction

  // Driver: present queued orders, predict on acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) match_order(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (order_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          s_axis_tdata <= order_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_start) begin
      hold_left <= HoldLen;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: compare each report with the oldest prediction
  always @(posedge clk_i) begin
    lom_pkg::report_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = lom_pkg::report_t'({m_axis_tlast, m_axis_tdata[148:0]});
      if (report_q.size() == 0) begin
        report_error("unexpected report seq", got.seq, '0);
      end else begin
        want = report_q.pop_front();
        if (got.seq != want.seq) report_error("order_seq", got.seq, want.seq);
        if (got.client != want.client) report_error("client", got.client, want.client);
        if (got.inst != want.inst) report_error("instrument", got.inst, want.inst);
        if (got.side != want.side) report_error("side", got.side, want.side);
        if (got.status != want.status) report_error("status", got.status, want.status);
        if (got.qty != want.qty) report_error("quantity", got.qty, want.qty);
        if (got.price != want.price) report_error("price", got.price, want.price);
        if (got.reason != want.reason) report_error("reason", got.reason, want.reason);
        if (got.last != want.last) report_error("tlast", got.last, want.last);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallMax) begin
      $display("limit_order_matcher_test NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (order_q.size() == 0 && !s_axis_tvalid && report_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      lom_pkg::CfgMinQty:  min_qty = val;
      lom_pkg::CfgMaxQty:  max_qty = val;
      lom_pkg::CfgLotSize: lot_qty = val;
      default:             max_clen = val[2:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_regs(logic [15:0] mn, logic [15:0] mx, logic [15:0] lot,
                          logic [2:0] clen);
    wait_idle();
    write_reg(lom_pkg::CfgMinQty, mn);
    write_reg(lom_pkg::CfgMaxQty, mx);
    write_reg(lom_pkg::CfgLotSize, lot);
    write_reg(lom_pkg::CfgMaxClen, {13'd0, clen});
  endtask

  task automatic push_random(int n);
    repeat (n) order_q.push_back(random_order());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: field extremes, the validation reject reasons, rest, fill, partial fill
    send_idle = 32; recv_idle = 77;
    order_q.push_back(pack_order('1, 4'd0, 3'd7, 2'd0, 32'h8000_0000, 16'hFFFF));
    order_q.push_back(pack_order('0, 4'd15, 3'd5, 2'd3, 32'd0, 16'd5));
    order_q.push_back(pack_order(56'h41, 4'd8, 3'd0, lom_pkg::SideBuy, 32'h7FFF_FFFF, 16'd15));
    order_q.push_back(pack_order(56'h42, 4'd7, 3'd4, lom_pkg::SideBuy, 32'h7FFF_FFFF,
                                 16'd1000));
    order_q.push_back(pack_order(56'h43, 4'd1, 3'd4, lom_pkg::SideSell, 32'd1, 16'd400));
    order_q.push_back(pack_order(56'h44, 4'd2, 3'd4, lom_pkg::SideSell, 32'd1, 16'd700));
    order_q.push_back(pack_order(56'h45, 4'd3, 3'd1, lom_pkg::SideSell, 32'd200, 16'd30));
    order_q.push_back(pack_order(56'h46, 4'd3, 3'd1, lom_pkg::SideSell, 32'd200, 16'd20));
    order_q.push_back(pack_order(56'h47, 4'd3, 3'd1, lom_pkg::SideSell, 32'd190, 16'd20));
    order_q.push_back(pack_order(56'h48, 4'd3, 3'd1, lom_pkg::SideBuy, 32'd250, 16'd60));
    order_q.push_back(pack_order(56'h49, 4'd3, 3'd1, lom_pkg::SideBuy, 32'd100, 16'd10));
    order_q.push_back(pack_order(56'h4A, 4'd3, 3'd1, lom_pkg::SideSell, 32'd100, 16'd10));
    order_q.push_back(pack_order(56'h4B, 4'd3, 3'd0, lom_pkg::SideBuy, 32'd100, 16'd1010));
    push_random(25);

    // loose size limits: zero quantity passes, no lot rule, one-character ids
    set_regs(16'd0, 16'hFFFF, 16'd0, 3'd1);
    order_q.push_back(pack_order(56'h51, 4'd1, 3'd2, lom_pkg::SideBuy, 32'd100, 16'd0));
    order_q.push_back(pack_order(56'h52, 4'd2, 3'd2, lom_pkg::SideBuy, 32'd100, 16'd7));
    order_q.push_back(pack_order(56'h53, 4'd1, 3'd2, lom_pkg::SideSell, 32'd90, 16'hFFFF));
    push_random(10);

    // tightest limits: every order rejected
    set_regs(16'hFFFF, 16'd0, 16'hFFFF, 3'd0);
    order_q.push_back(pack_order(56'h61, 4'd1, 3'd0, lom_pkg::SideBuy, 32'd100, 16'hFFFF));
    push_random(5);

    // fill one book side while the receiver holds off, then sweep it
    set_regs(16'd1, 16'd500, 16'd1, 3'd7);
    @(posedge clk_i);
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    for (int i = 0; i < Depth + 2; i++)
      order_q.push_back(pack_order(56'h100 + i, 4'd7, 3'd3, lom_pkg::SideBuy, 32'd100 + i,
                                   16'd10));
    order_q.push_back(pack_order(56'h200, 4'd7, 3'd3, lom_pkg::SideSell, 32'd50, 16'd200));
    order_q.push_back(pack_order(56'h201, 4'd7, 3'd3, lom_pkg::SideBuy, 32'd60, 16'd5));

    // random with idling swapped, then with none
    set_regs(16'd5, 16'd300, 16'd5, 3'd5);
    send_idle = 77; recv_idle = 32;
    push_random(17);
    wait_idle();
    send_idle = 0; recv_idle = 0;
    push_random(17);

    wait_idle();
    repeat (400) @(posedge clk_i);
    if (error_count == 0 && report_q.size() == 0)
      $display("limit_order_matcher_test OK");
    else
      $display("limit_order_matcher_test NOT OK");
    $finish;
  end

endmodule

// ===== limit_order_matcher.f =====
rtl/core/lom_pkg.sv
rtl/core/lom_ram.sv
rtl/core/limit_order_matcher.sv
tb/sv/limit_order_matcher_test.sv
